FILE: hw/rtl/crccf_pkg.sv
// shared types, character codes and the crc-8 step for the command frame parser
// used by crccf_ctrl, crccf_datapath and the top level
`timescale 1ns / 1ps

package crccf_pkg;

  localparam logic [7:0] CRC_POLY       = 8'h8C;
  localparam logic [7:0] FRAME_END_INIT = 8'd59;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ARG    = 1'b1;

  localparam logic [5:0] TOKEN_MAX = 6'd63;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CLOSE,
    ST_SEND
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  typedef struct packed {
    logic byte_en;
    logic close_en;
    logic emit_start;
    logic emit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic emit_last;
  } dp_status_t;

  typedef struct packed {
    logic               kind;
    logic               crc_ok;
    logic [7:0]         computed_crc;
    logic [7:0]         received_crc;
    logic [63:0]        command_name;
    logic [5:0]         name_length;
    logic [2:0]         arg_count;
    logic               args_dropped;
    logic [2:0]         arg_index;
    logic signed [15:0] arg_value;
    logic               last;
  } result_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      mix = crc[0] ^ data[k];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/crc_checked_command_frame_parser.sv
// Command frame parser with crc-8 check.
// Input stream s_axis: one received byte per word. The first byte of a frame is
// the check byte; later bytes run through the crc and the tokenizer until the
// byte equal to the frame_end register (reset 59). The user must write it
// via cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// Output stream m_axis: at each terminator one header word (tuser 0), then one
// word per kept argument (tuser 1) if the check passes; tlast marks the final word.
// Throughput: one byte per cycle while a frame is being received. After the
// terminator is taken the controller closes the last token in ST_CLOSE, then
// presents the header in ST_SEND; each further result word follows once the
// current one is taken with m_axis_tready high, and s_axis_tready is low from
// the terminator on until the last result word is taken.
// A receiver stall simply holds the current result word and the input side.
// A frame longer than FRAME_BYTES drops the next byte and restarts at the byte
// after it. Reset clears the parser and returns frame_end to 59.
// depends on crccf_pkg, crccf_ctrl and crccf_datapath
`timescale 1ns / 1ps

module crc_checked_command_frame_parser #(
  parameter int FRAME_BYTES = 64,
  parameter int ARG_SLOTS   = 8,
  parameter int NAME_CHARS  = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,      // frame_end
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // crc_ok[0], computed_crc[8:1], received_crc[16:9], command_name[80:17],
  // name_length[86:81], arg_count[89:87], args_dropped[90], arg_index[93:91],
  // arg_value[109:94], zero pad[111:110]
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last
);
  import crccf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  crccf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  crccf_datapath #(
    .FRAME_BYTES (FRAME_BYTES),
    .ARG_SLOTS   (ARG_SLOTS),
    .NAME_CHARS  (NAME_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  assign m_axis_tdata = {2'b00, result.arg_value, result.arg_index, result.args_dropped,
                         result.arg_count, result.name_length, result.command_name,
                         result.received_crc, result.computed_crc, result.crc_ok};
  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.last;

endmodule

FILE: hw/rtl/crccf_ctrl.sv
// controller state machine: receive bytes, close the last token, send results
// depends on crccf_pkg for the state and command/status types
`timescale 1ns / 1ps

module crccf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  crccf_pkg::dp_status_t status,
  output crccf_pkg::dp_cmd_t    cmd
);
  import crccf_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    cmd           = '0;
    case (state)
      ST_RECV: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.byte_en = 1'b1;
          if (status.frame_done) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        // terminator may have been part of an open token
        cmd.close_en   = 1'b1;
        cmd.emit_start = 1'b1;
        state_next     = ST_SEND;
      end
      ST_SEND: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (status.emit_last) begin
            state_next = ST_RECV;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

endmodule

FILE: hw/rtl/crccf_datapath.sv
// datapath: frame counter, crc, tokenizer, number reader, argument store, result mux
// depends on crccf_pkg; driven by crccf_ctrl through dp_cmd_t
`timescale 1ns / 1ps

module crccf_datapath #(
  parameter int FRAME_BYTES = 64,
  parameter int ARG_SLOTS   = 8,
  parameter int NAME_CHARS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic [7:0]            rx_byte,
  input  crccf_pkg::dp_cmd_t    cmd,
  output crccf_pkg::dp_status_t status,
  output crccf_pkg::result_t    result
);
  import crccf_pkg::*;

  localparam int FCW        = $clog2(FRAME_BYTES + 1);
  localparam int SLOTS_USED = ARG_SLOTS - 1;
  localparam int AIW        = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;

  logic [7:0]        frame_end;
  logic [FCW-1:0]    frame_count, frame_count_next;
  logic [7:0]        check_byte, check_byte_next;
  logic [7:0]        crc_running, crc_running_next;
  logic [5:0]        token_number, token_number_next;
  logic              inside_token, inside_token_next;
  logic              text_stopped, text_stopped_next;
  logic [63:0]       name_store, name_store_next;
  logic [5:0]        name_len, name_len_next;
  logic [15:0]       number_accum, number_accum_next;
  num_phase_t        number_phase, number_phase_next;
  logic              number_negative, number_negative_next;
  logic              dropped_flag, dropped_flag_next;
  logic [5:0]        emit_idx, emit_idx_next;
  logic [15:0]       arg_store [SLOTS_USED];
  logic [15:0]       arg_rd;

  logic              ovf, is_term, is_digit, is_space, is_delim, close_req;
  logic [3:0]        digit;
  logic [5:0]        tok_eff;
  logic [15:0]       acc_eff;
  num_phase_t        ph_eff;
  logic              wr_en;
  logic [5:0]        wr_idx6, tok_less1, arg_cnt;
  logic [15:0]       wr_data;
  logic              crc_ok;

  assign ovf      = frame_count >= FCW'(FRAME_BYTES);
  assign is_term  = rx_byte == frame_end;
  assign is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
  assign is_space = rx_byte inside {[CH_TAB:CH_CR], CH_SPACE};
  assign is_delim = rx_byte inside {CH_SPACE, CH_COMMA, CH_LPAREN, CH_RPAREN, CH_SEMI};
  assign digit    = rx_byte[3:0];

  assign status.frame_done = !ovf && is_term;

  always_comb begin
    frame_count_next     = frame_count;
    check_byte_next      = check_byte;
    crc_running_next     = crc_running;
    token_number_next    = token_number;
    inside_token_next    = inside_token;
    text_stopped_next    = text_stopped;
    name_store_next      = name_store;
    name_len_next        = name_len;
    number_accum_next    = number_accum;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    dropped_flag_next    = dropped_flag;
    close_req            = 1'b0;
    tok_eff              = token_number;
    acc_eff              = number_accum;
    ph_eff               = number_phase;

    if (cmd.byte_en) begin
      if (ovf) begin
        // byte dropped, next byte opens a new frame
        frame_count_next = '0;
      end else if (frame_count == '0) begin
        check_byte_next      = rx_byte;
        crc_running_next     = '0;
        token_number_next    = '0;
        inside_token_next    = 1'b0;
        text_stopped_next    = 1'b0;
        name_store_next      = '0;
        name_len_next        = '0;
        number_accum_next    = '0;
        number_phase_next    = PH_LEAD;
        number_negative_next = 1'b0;
        dropped_flag_next    = 1'b0;
        frame_count_next     = is_term ? '0 : FCW'(1);
      end else begin
        crc_running_next = crc8_update(crc_running, rx_byte);
        frame_count_next = is_term ? '0 : frame_count + FCW'(1);
        if (!text_stopped) begin
          if (rx_byte == CH_NUL) begin
            close_req         = 1'b1;
            text_stopped_next = 1'b1;
          end else if (is_delim) begin
            close_req = 1'b1;
          end else begin
            if (!inside_token) begin
              inside_token_next    = 1'b1;
              if (token_number < TOKEN_MAX) begin
                tok_eff = token_number + 6'd1;
              end
              acc_eff              = '0;
              ph_eff               = PH_LEAD;
              number_negative_next = 1'b0;
            end
            token_number_next = tok_eff;
            number_accum_next = acc_eff;
            number_phase_next = ph_eff;
            if (tok_eff == 6'd1) begin
              if (name_len < 6'(NAME_CHARS)) begin
                name_store_next = name_store | (64'(rx_byte) << {name_len[2:0], 3'b000});
              end
              if (name_len < TOKEN_MAX) begin
                name_len_next = name_len + 6'd1;
              end
            end else begin
              case (ph_eff)
                PH_LEAD: begin
                  if (is_space) begin
                    number_phase_next = PH_LEAD;
                  end else if (rx_byte == CH_PLUS) begin
                    number_phase_next = PH_DIGITS;
                  end else if (rx_byte == CH_MINUS) begin
                    number_negative_next = 1'b1;
                    number_phase_next    = PH_DIGITS;
                  end else if (is_digit) begin
                    number_accum_next = 16'(digit);
                    number_phase_next = PH_DIGITS;
                  end else begin
                    number_phase_next = PH_DONE;
                  end
                end
                PH_DIGITS: begin
                  if (is_digit) begin
                    // times ten as two shifts
                    number_accum_next = (acc_eff << 3) + (acc_eff << 1) + 16'(digit);
                  end else begin
                    number_phase_next = PH_DONE;
                  end
                end
                default: begin
                  number_phase_next = ph_eff;
                end
              endcase
            end
          end
        end
      end
    end

    if (cmd.close_en) begin
      close_req = 1'b1;
    end

    // token close: store the argument or flag it as dropped
    tok_less1 = token_number - 6'd1;
    wr_idx6   = token_number - 6'd2;
    wr_data   = number_negative ? (16'd0 - number_accum) : number_accum;
    wr_en     = 1'b0;
    if (close_req) begin
      inside_token_next = 1'b0;
      if (inside_token && token_number >= 6'd2) begin
        if (tok_less1 <= 6'(SLOTS_USED)) begin
          wr_en = 1'b1;
        end else begin
          dropped_flag_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    emit_idx_next = emit_idx;
    if (cmd.emit_start) begin
      emit_idx_next = '0;
    end else if (cmd.emit_next) begin
      emit_idx_next = emit_idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_end       <= FRAME_END_INIT;
      frame_count     <= '0;
      check_byte      <= '0;
      crc_running     <= '0;
      token_number    <= '0;
      inside_token    <= 1'b0;
      text_stopped    <= 1'b0;
      name_store      <= '0;
      name_len        <= '0;
      number_accum    <= '0;
      number_phase    <= PH_LEAD;
      number_negative <= 1'b0;
      dropped_flag    <= 1'b0;
      emit_idx        <= '0;
    end else begin
      if (cfg_we) begin
        frame_end <= cfg_wdata;
      end
      frame_count     <= frame_count_next;
      check_byte      <= check_byte_next;
      crc_running     <= crc_running_next;
      token_number    <= token_number_next;
      inside_token    <= inside_token_next;
      text_stopped    <= text_stopped_next;
      name_store      <= name_store_next;
      name_len        <= name_len_next;
      number_accum    <= number_accum_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      dropped_flag    <= dropped_flag_next;
      emit_idx        <= emit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      arg_store[wr_idx6[AIW-1:0]] <= wr_data;
    end
    // fetch the slot of the argument word that comes next
    if (cmd.emit_next) begin
      arg_rd <= arg_store[emit_idx[AIW-1:0]];
    end
  end

  // result selection
  assign crc_ok  = crc_running == check_byte;
  assign arg_cnt = (crc_ok && token_number >= 6'd2)
                   ? ((tok_less1 > 6'(SLOTS_USED)) ? 6'(SLOTS_USED) : tok_less1)
                   : 6'd0;
  assign status.emit_last = emit_idx == arg_cnt;

  always_comb begin
    result      = '0;
    result.last = emit_idx == arg_cnt;
    if (emit_idx == 6'd0) begin
      result.kind         = KIND_HEADER;
      result.crc_ok       = crc_ok;
      result.computed_crc = crc_running;
      result.received_crc = check_byte;
      if (crc_ok) begin
        result.command_name = name_store;
        result.name_length  = name_len;
        result.arg_count    = arg_cnt[2:0];
        result.args_dropped = dropped_flag;
      end
    end else begin
      result.kind      = KIND_ARG;
      result.arg_index = emit_idx[2:0];
      result.arg_value = arg_rd;
    end
  end

endmodule

FILE: hw/rtl/crccf_checker.sv
// port-level checks for the command frame parser, bound to the top level
// depends only on the ports of crc_checked_command_frame_parser
`timescale 1ns / 1ps

module crccf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // input is never taken while results are pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while results pending");

  // argument words carry a nonzero position
  a_argidx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[93:91] != 3'd0)
    else $error("argument word with zero index");

  // a failed check ends the frame at the header
  a_badcrc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && !m_axis_tdata[0] |-> m_axis_tlast)
    else $error("failed check header not last");

endmodule

bind crc_checked_command_frame_parser crccf_checker u_crccf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
